FILE: rtl/core/pidb_pkg.sv
// Package for the PID controller block: widths, constants, codes and shared types.
// No dependencies; imported by every other file of the block.
package pidb_pkg;

  // Value and fixed point widths
  localparam int VW  = 32;  // signed Q16.16 values
  localparam int FW  = 16;  // fraction bits
  localparam int GW  = 31;  // gain and period register width
  localparam int TFB = 32;  // fraction bits of the step time
  localparam int TW  = 42;  // step time width
  localparam int EW  = 33;  // elapsed-ms step time width
  localparam int PTW = 48;  // proportional term width (signed)
  localparam int KKW = 46;  // kd*kp width

  // Multiplier: A operand by B operand taken in MD-bit digits
  localparam int MA = 64;
  localparam int MB = 48;
  localparam int MD = 16;
  localparam int PW = MA + MB;
  localparam int MW = 63;   // capped signed product width

  // Divider
  localparam int QW = 47;
  localparam int CW = $clog2(QW + 1);
  localparam int DIV_DER_N = 31;

  // Input queue depth
  localparam int QD = 2;

  localparam logic [26:0] STEP_C = 27'd71725954;
  localparam logic [16:0] MS_C   = 17'd71726;
  localparam logic [MW-2:0] CAP  = {1'b1, 61'd0};

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] OUT_HIGH_RST = 32'sd6553600;
  localparam logic signed [VW-1:0] OUT_LOW_RST  = -32'sd6553600;

  typedef enum logic [1:0] {
    LIM_NONE = 2'd0,
    LIM_HIGH = 2'd1,
    LIM_LOW  = 2'd2
  } lim_e;

  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_PERIOD = 3'd3,
    REG_HIGH   = 3'd4,
    REG_LOW    = 3'd5,
    REG_REINIT = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    SH_FRAC = 2'd0,
    SH_HALF = 2'd1,
    SH_STEP = 2'd2
  } shift_e;

  typedef struct packed {
    logic [GW-1:0]        kp;
    logic [GW-1:0]        ki;
    logic [GW-1:0]        kd;
    logic [GW-1:0]        period;
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] lo;
    logic                 reinit;
  } cfg_t;

  // One classified request waiting for the back end
  typedef struct packed {
    logic signed [VW-1:0] meas;
    logic signed [VW-1:0] err;
    logic [EW-1:0]        tf_ms;
    logic                 use_period;
  } item_t;

  typedef struct packed {
    logic          start;
    logic [MA-1:0] a;
    logic [MB-1:0] b;
    shift_e        sh;
    logic          neg;
  } mul_req_t;

  typedef struct packed {
    logic          start;
    logic [TW-1:0] rem;
    logic [QW-1:0] dvd;
    logic [CW-1:0] n;
    logic [TW-1:0] d;
  } div_req_t;

  // Saturate to the signed value range
  function automatic logic signed [VW-1:0] sat_v(input logic signed [63:0] v);
    logic signed [VW-1:0] r;
    if (v > 64'(VMAX)) begin
      r = VMAX;
    end else if (v < 64'(VMIN)) begin
      r = VMIN;
    end else begin
      r = v[VW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pidb_if.sv
// Channel interfaces of the PID controller: input request, result and config write.
// Depends on pidb_pkg.
interface pidb_in_if;
  import pidb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] measured;
  logic signed [VW-1:0] setpoint;
  logic [15:0]          elapsed_ms;
  modport source (output valid, measured, setpoint, elapsed_ms, input ready);
  modport sink (input valid, measured, setpoint, elapsed_ms, output ready);
endinterface

interface pidb_out_if;
  import pidb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] drive;
  logic [1:0]           limited;
  modport source (output valid, drive, limited, input ready);
  modport sink (input valid, drive, limited, output ready);
endinterface

interface pidb_cfg_if;
  import pidb_pkg::*;
  logic          valid;
  logic          ready;
  logic [2:0]    index;
  logic [VW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pidb_front.sv
// Front end: takes requests, forms the saturated error and the elapsed-time step,
// and holds them in a two-entry queue. Depends on pidb_pkg and pidb_if.
module pidb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pidb_pkg::cfg_t  cfg_i,
  pidb_in_if.sink         req_i,
  output logic            q_valid_o,
  output pidb_pkg::item_t q_item_o,
  input  logic            q_ready_i
);
  import pidb_pkg::*;

  localparam int PTRW = $clog2(QD);

  item_t                fifo_q [QD];
  logic [PTRW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTRW:0]        cnt_q, cnt_d;
  logic                 push, pop;
  logic signed [VW:0]   err_w;
  item_t                item_new;

  // Classify the incoming request
  always_comb begin
    err_w               = $signed({req_i.setpoint[VW-1], req_i.setpoint})
                        - $signed({req_i.measured[VW-1], req_i.measured});
    item_new.meas       = req_i.measured;
    item_new.err        = sat_v(64'(err_w));
    item_new.tf_ms      = cfg_i.reinit ? '0 : EW'(req_i.elapsed_ms) * EW'(MS_C);
    item_new.use_period = (cfg_i.period != '0);
  end

  assign req_i.ready = (cnt_q != (PTRW+1)'(QD));
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign pop         = q_valid_o && q_ready_i;
  assign q_item_o    = fifo_q[rd_ptr_q];

  // Queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_new;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PTRW+1)'(QD)) else $error("queue count beyond depth");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PTRW+1)'(QD)) |-> !req_i.ready) else $error("full queue takes a request");
  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("queue count lost a push");
`endif

endmodule

FILE: rtl/core/pidb_mul.sv
// Shared multiplier: 64-bit magnitude times 48-bit magnitude, one 16-bit digit per
// cycle, then a truncating right shift, a cap at 2^61 and the sign. Uses pidb_pkg.
module pidb_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidb_pkg::mul_req_t  req_i,
  output logic                done_o,
  output logic signed [62:0]  res_o
);
  import pidb_pkg::*;

  localparam int ND  = MB / MD;
  localparam int NCW = $clog2(ND + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [NCW-1:0]   cnt_q, cnt_d;
  logic [MA-1:0]    a_q;
  logic [MB-1:0]    b_q;
  logic [PW-1:0]    acc_q;
  shift_e           sh_q;
  logic             neg_q;
  logic [MA+MD-1:0] pp;
  logic [PW-1:0]    shv;
  logic [MW-2:0]    mag;

  // One partial product per cycle, most significant digit first
  assign pp = a_q * b_q[MB-1 -: MD];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = NCW'(ND);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == NCW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      sh_q  <= req_i.sh;
      neg_q <= req_i.neg;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << MD) + PW'(pp);
      b_q   <= b_q << MD;
    end
  end

  // Scale, cap and sign
  always_comb begin
    case (sh_q)
      SH_FRAC: shv = acc_q >> FW;
      SH_HALF: shv = acc_q >> (FW + 1);
      SH_STEP: shv = acc_q >> TFB;
      default: shv = acc_q >> FW;
    endcase
    mag = (shv > PW'(CAP)) ? CAP : shv[MW-2:0];
  end

  assign res_o  = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign done_o = done_q;

endmodule

FILE: rtl/core/pidb_div.sv
// Shared restoring divider, one quotient bit per cycle, with a preset partial
// remainder so callers can skip leading quotient bits. Uses pidb_pkg.
module pidb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidb_pkg::div_req_t req_i,
  output logic               done_o,
  output logic [46:0]        q_o
);
  import pidb_pkg::*;

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] rem_q, d_q;
  logic [QW-1:0] dvd_q, quo_q;
  logic [TW:0]   trial, diff;
  logic          ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_q, dvd_q[QW-1]};
    diff  = trial - {1'b0, d_q};
    ge    = (trial >= {1'b0, d_q});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.n;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      dvd_q <= req_i.dvd;
      d_q   <= req_i.d;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TW-1:0] : trial[TW-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = quo_q;

endmodule

FILE: rtl/core/pidb_back.sv
// Back end: sequences one request through the shared multiplier and divider,
// keeps the controller history and holds the result register. Uses pidb_pkg,
// pidb_if, pidb_mul and pidb_div.
module pidb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pidb_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  pidb_pkg::item_t q_item_i,
  output logic            q_ready_o,
  pidb_out_if.source      rsp_o
);
  import pidb_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TF   = 4'd1;
  localparam logic [3:0] ST_PT   = 4'd2;
  localparam logic [3:0] ST_DER  = 4'd3;
  localparam logic [3:0] ST_KK   = 4'd4;
  localparam logic [3:0] ST_NUM  = 4'd5;
  localparam logic [3:0] ST_DCHK = 4'd6;
  localparam logic [3:0] ST_DDIV = 4'd7;
  localparam logic [3:0] ST_INT  = 4'd8;
  localparam logic [3:0] ST_RAT  = 4'd9;
  localparam logic [3:0] ST_IA   = 4'd10;
  localparam logic [3:0] ST_IB   = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  logic [3:0]            st_q, st_d;
  logic                  issued_q, issued_d;

  // Per-request working registers
  item_t                 item_q, item_d;
  logic [TW-1:0]         tf_q, tf_d;
  logic signed [PTW-1:0] pterm_q, pterm_d;
  logic [KKW-1:0]        kk_q, kk_d;
  logic signed [MW-1:0]  num_q, num_d;
  logic [QW-1:0]         ratio_q, ratio_d;
  logic signed [MW-1:0]  ia_q, ia_d;
  logic signed [VW-1:0]  gap_q, gap_d;
  logic signed [VW-1:0]  res_drive_q, res_drive_d;
  lim_e                  res_lim_q, res_lim_d;

  // Controller history
  logic signed [VW-1:0]  prev_meas_q, prev_meas_d;
  logic signed [VW-1:0]  prev_err_q, prev_err_d;
  logic signed [VW-1:0]  iacc_q, iacc_d;
  logic signed [VW-1:0]  dterm_q, dterm_d;
  logic signed [VW-1:0]  last_drive_q, last_drive_d;
  logic                  first_q, first_d;
  logic [GW-1:0]         lg_q [3];
  logic [GW-1:0]         lg_d [3];

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic signed [VW-1:0]  out_drive_q;
  lim_e                  out_lim_q;
  logic                  out_load;

  mul_req_t              mreq;
  div_req_t              dreq;
  logic                  mul_done, div_done;
  logic signed [MW-1:0]  mul_res;
  logic [QW-1:0]         div_q;

  logic [VW-1:0]         emag;
  logic signed [VW:0]    dif, esum;
  logic [VW:0]           dif_mag, esum_mag;
  logic [MW-2:0]         nmag, amag;
  logic                  same_gains, in_range;
  logic signed [PTW:0]   fsum;

  pidb_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  pidb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (div_done),
    .q_o    (div_q)
  );

  // Magnitudes and tests shared by several steps
  always_comb begin
    emag       = item_q.err[VW-1] ? (~item_q.err + 1'b1) : item_q.err;
    dif        = $signed({prev_meas_q[VW-1], prev_meas_q})
               - $signed({item_q.meas[VW-1], item_q.meas});
    dif_mag    = dif[VW] ? (~dif + 1'b1) : dif;
    esum       = $signed({item_q.err[VW-1], item_q.err})
               + $signed({prev_err_q[VW-1], prev_err_q});
    esum_mag   = esum[VW] ? (~esum + 1'b1) : esum;
    nmag       = num_q[MW-1] ? (MW-1)'(~num_q + 1'b1) : num_q[MW-2:0];
    amag       = ia_q[MW-1] ? (MW-1)'(~ia_q + 1'b1) : ia_q[MW-2:0];
    same_gains = (cfg_i.kp == lg_q[0]) && (cfg_i.ki == lg_q[1]) && (cfg_i.kd == lg_q[2]);
    in_range   = (pterm_q <= cfg_i.hi) && (pterm_q >= cfg_i.lo);
    fsum       = (PTW+1)'(pterm_q) + (PTW+1)'(gap_q) + (PTW+1)'(dterm_q);
  end

  // Sequencer
  always_comb begin
    st_d         = st_q;
    issued_d     = issued_q;
    item_d       = item_q;
    tf_d         = tf_q;
    pterm_d      = pterm_q;
    kk_d         = kk_q;
    num_d        = num_q;
    ratio_d      = ratio_q;
    ia_d         = ia_q;
    gap_d        = gap_q;
    res_drive_d  = res_drive_q;
    res_lim_d    = res_lim_q;
    prev_meas_d  = prev_meas_q;
    prev_err_d   = prev_err_q;
    iacc_d       = iacc_q;
    dterm_d      = dterm_q;
    last_drive_d = last_drive_q;
    first_d      = first_q;
    lg_d         = lg_q;
    q_ready_o    = 1'b0;
    out_load     = 1'b0;
    mreq         = '0;
    dreq         = '0;

    case (st_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          item_d   = q_item_i;
          tf_d     = TW'(q_item_i.tf_ms);
          issued_d = 1'b0;
          st_d     = q_item_i.use_period ? ST_TF : ST_PT;
        end
      end

      // Step time from the fixed period
      ST_TF: begin
        mreq.a  = MA'(cfg_i.period);
        mreq.b  = MB'(STEP_C);
        mreq.sh = SH_FRAC;
        if (!issued_q) begin
          mreq.start = 1'b1;
          issued_d   = 1'b1;
        end else if (mul_done) begin
          tf_d     = mul_res[TW-1:0];
          issued_d = 1'b0;
          st_d     = ST_PT;
        end
      end

      // Proportional term
      ST_PT: begin
        mreq.a   = MA'(emag);
        mreq.b   = MB'(cfg_i.kp);
        mreq.sh  = SH_FRAC;
        mreq.neg = item_q.err[VW-1];
        if (!issued_q) begin
          mreq.start = 1'b1;
          issued_d   = 1'b1;
        end else if (mul_done) begin
          pterm_d  = mul_res[PTW-1:0];
          issued_d = 1'b0;
          st_d     = ST_DER;
        end
      end

      // Derivative update decision
      ST_DER: begin
        if (!cfg_i.reinit || first_q) begin
          st_d = (tf_q != '0) ? ST_KK : ST_INT;
        end else begin
          prev_meas_d = item_q.meas;
          dterm_d     = '0;
          st_d        = ST_INT;
        end
      end

      ST_KK: begin
        mreq.a  = MA'(cfg_i.kd);
        mreq.b  = MB'(cfg_i.kp);
        mreq.sh = SH_FRAC;
        if (!issued_q) begin
          mreq.start = 1'b1;
          issued_d   = 1'b1;
        end else if (mul_done) begin
          kk_d     = mul_res[KKW-1:0];
          issued_d = 1'b0;
          st_d     = ST_NUM;
        end
      end

      ST_NUM: begin
        mreq.a   = MA'(kk_q);
        mreq.b   = MB'(dif_mag);
        mreq.sh  = SH_FRAC;
        mreq.neg = dif[VW];
        if (!issued_q) begin
          mreq.start = 1'b1;
          issued_d   = 1'b1;
        end else if (mul_done) begin
          num_d    = mul_res;
          issued_d = 1'b0;
          st_d     = ST_DCHK;
        end
      end

      // Quotient of 2^31 or more saturates without dividing
      ST_DCHK: begin
        if ({nmag, 1'b0} >= MW'(tf_q)) begin
          dterm_d     = num_q[MW-1] ? VMIN : VMAX;
          prev_meas_d = item_q.meas;
          st_d        = ST_INT;
        end else begin
          st_d = ST_DDIV;
        end
      end

      ST_DDIV: begin
        dreq.rem = {nmag[TW-2:0], 1'b0};
        dreq.dvd = '0;
        dreq.n   = CW'(DIV_DER_N);
        dreq.d   = tf_q;
        if (!issued_q) begin
          dreq.start = 1'b1;
          issued_d   = 1'b1;
        end else if (div_done) begin
          dterm_d     = num_q[MW-1] ? -$signed({1'b0, div_q[VW-2:0]})
                                    : $signed({1'b0, div_q[VW-2:0]});
          prev_meas_d = item_q.meas;
          issued_d    = 1'b0;
          st_d        = ST_INT;
        end
      end

      // Integral path selection
      ST_INT: begin
        if (cfg_i.ki == '0) begin
          gap_d = '0;
          st_d  = ST_FIN;
        end else if (cfg_i.reinit || first_q || same_gains) begin
          if (in_range) begin
            if (cfg_i.reinit) begin
              iacc_d = '0;
              gap_d  = '0;
              st_d   = ST_FIN;
            end else begin
              st_d = ST_RAT;
            end
          end else begin
            if (pterm_q > cfg_i.hi) begin
              iacc_d = sat_v(64'(cfg_i.hi) - 64'(pterm_q));
            end else begin
              iacc_d = sat_v(64'(cfg_i.lo) - 64'(pterm_q));
            end
            gap_d = iacc_d;
            st_d  = ST_FIN;
          end
        end else begin
          // Gain hand-over: hold the drive, re-seed the integral
          iacc_d      = sat_v(64'(last_drive_q) - (64'(pterm_q) + 64'(dterm_q)));
          res_drive_d = last_drive_q;
          res_lim_d   = LIM_NONE;
          lg_d[0]     = cfg_i.kp;
          lg_d[1]     = cfg_i.ki;
          lg_d[2]     = cfg_i.kd;
          prev_err_d  = item_q.err;
          first_d     = 1'b0;
          st_d        = ST_OUT;
        end
      end

      ST_RAT: begin
        dreq.rem = '0;
        dreq.dvd = {cfg_i.kp, FW'(0)};
        dreq.n   = CW'(QW);
        dreq.d   = TW'(cfg_i.ki);
        if (!issued_q) begin
          dreq.start = 1'b1;
          issued_d   = 1'b1;
        end else if (div_done) begin
          ratio_d  = div_q;
          issued_d = 1'b0;
          st_d     = ST_IA;
        end
      end

      ST_IA: begin
        mreq.a   = MA'(ratio_q);
        mreq.b   = MB'(esum_mag);
        mreq.sh  = SH_HALF;
        mreq.neg = esum[VW];
        if (!issued_q) begin
          mreq.start = 1'b1;
          issued_d   = 1'b1;
        end else if (mul_done) begin
          ia_d     = mul_res;
          issued_d = 1'b0;
          st_d     = ST_IB;
        end
      end

      ST_IB: begin
        mreq.a   = MA'(amag);
        mreq.b   = MB'(tf_q);
        mreq.sh  = SH_STEP;
        mreq.neg = ia_q[MW-1];
        if (!issued_q) begin
          mreq.start = 1'b1;
          issued_d   = 1'b1;
        end else if (mul_done) begin
          iacc_d   = sat_v(64'(mul_res) + 64'(iacc_q));
          gap_d    = iacc_d;
          issued_d = 1'b0;
          st_d     = ST_FIN;
        end
      end

      // Sum, clamp (high test first) and record history
      ST_FIN: begin
        if (fsum > (PTW+1)'(cfg_i.hi)) begin
          res_drive_d = cfg_i.hi;
          res_lim_d   = LIM_HIGH;
        end else if (fsum < (PTW+1)'(cfg_i.lo)) begin
          res_drive_d = cfg_i.lo;
          res_lim_d   = LIM_LOW;
        end else begin
          res_drive_d = fsum[VW-1:0];
          res_lim_d   = LIM_NONE;
        end
        last_drive_d = res_drive_d;
        lg_d[0]      = cfg_i.kp;
        lg_d[1]      = cfg_i.ki;
        lg_d[2]      = cfg_i.kd;
        prev_err_d   = item_q.err;
        first_d      = 1'b0;
        st_d         = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      issued_q     <= 1'b0;
      prev_meas_q  <= '0;
      prev_err_q   <= '0;
      iacc_q       <= '0;
      dterm_q      <= '0;
      last_drive_q <= '0;
      first_q      <= 1'b1;
      lg_q[0]      <= '0;
      lg_q[1]      <= '0;
      lg_q[2]      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      issued_q     <= issued_d;
      prev_meas_q  <= prev_meas_d;
      prev_err_q   <= prev_err_d;
      iacc_q       <= iacc_d;
      dterm_q      <= dterm_d;
      last_drive_q <= last_drive_d;
      first_q      <= first_d;
      lg_q         <= lg_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    tf_q        <= tf_d;
    pterm_q     <= pterm_d;
    kk_q        <= kk_d;
    num_q       <= num_d;
    ratio_q     <= ratio_d;
    ia_q        <= ia_d;
    gap_q       <= gap_d;
    res_drive_q <= res_drive_d;
    res_lim_q   <= res_lim_d;
    if (out_load) begin
      out_drive_q <= res_drive_q;
      out_lim_q   <= res_lim_q;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.drive   = out_drive_q;
  assign rsp_o.limited = out_lim_q;

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mreq.start && dreq.start)) else $error("multiplier and divider started together");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !(mul_done || div_done)) else $error("unit finished while idle");
  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> ($past(st_q) == ST_FIN || $past(st_q) == ST_INT))
    else $error("first-step flag cleared outside result formation");
`endif

endmodule

FILE: rtl/core/pid_controller_bumpless_top.sv
// PID controller with anti-windup, bumpless gain hand-over and reinitialize mode.
// Request channel req_i carries measured, setpoint and elapsed_ms; result channel
// rsp_o carries drive and limited (0 in range, 1 clamped high, 2 clamped low).
// Both are valid/ready; a request or result moves when valid and ready are high.
// Config channel cfg_i writes register index 0..6 (kp, ki, kd, sample period,
// out high, out low, reinit mode) and is always ready; write it only while idle.
// A front queue of two entries feeds a sequencer that runs up to six multiplies
// (16-bit digits) and two bit-serial divisions (31 and 47 steps) on one shared
// multiplier and divider.
// One request is computed at a time; up to two more wait in the front queue.
// The finished result sits in an output register; while the receiver stalls the
// sequencer holds one further result and then stops, and the queue fills.
// Reset clears all history, sets the first-step flag and loads the limits to
// +100.0 / -100.0 with all gains zero. Depends on pidb_pkg, pidb_if, pidb_front,
// pidb_back.
module pid_controller_bumpless_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pidb_in_if.sink    req_i,
  pidb_out_if.source rsp_o,
  pidb_cfg_if.sink   cfg_i
);
  import pidb_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  q_valid, q_ready;
  item_t q_item;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (reg_e'(cfg_i.index))
        REG_KP:     cfg_d.kp     = cfg_i.data[GW-1:0];
        REG_KI:     cfg_d.ki     = cfg_i.data[GW-1:0];
        REG_KD:     cfg_d.kd     = cfg_i.data[GW-1:0];
        REG_PERIOD: cfg_d.period = cfg_i.data[GW-1:0];
        REG_HIGH:   cfg_d.hi     = cfg_i.data;
        REG_LOW:    cfg_d.lo     = cfg_i.data;
        REG_REINIT: cfg_d.reinit = cfg_i.data[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp     <= '0;
      cfg_q.ki     <= '0;
      cfg_q.kd     <= '0;
      cfg_q.period <= '0;
      cfg_q.hi     <= OUT_HIGH_RST;
      cfg_q.lo     <= OUT_LOW_RST;
      cfg_q.reinit <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pidb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  pidb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ready_o (q_ready),
    .rsp_o     (rsp_o)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for pid_controller_bumpless_top: directed and random
// requests under several register settings, checked against an in-bench predictor.
// Depends on pidb_pkg, pidb_if and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pidb_pkg::*;

  localparam longint LIMIT_CYCLES = 2000000;
  localparam logic [63:0] CAP64 = 64'h2000_0000_0000_0000;
  localparam longint STEP_K = 71725954;
  localparam longint MS_K = 71726;

  typedef struct {
    logic signed [VW-1:0] drive;
    lim_e                 limited;
  } drive_t;

  // Predicts drive results and holds them in request order
  class pid_scoreboard;
    longint kp, ki, kd, period, hi_lim, lo_lim;
    bit     reinit;
    longint prev_meas, prev_err, integ, deriv, last_drive;
    bit     first;
    longint gain_hist[3];
    drive_t pending_drive[$];
    int     mismatches, results, requests, clamps, handovers;

    function new();
      kp = 0; ki = 0; kd = 0; period = 0;
      hi_lim = OUT_HIGH_RST; lo_lim = OUT_LOW_RST; reinit = 0;
      prev_meas = 0; prev_err = 0; integ = 0; deriv = 0; last_drive = 0;
      first = 1;
      gain_hist = '{0, 0, 0};
    endfunction

    function int pending();
      return pending_drive.size();
    endfunction

    function longint sat32(longint v);
      return v > longint'(VMAX) ? longint'(VMAX) : (v < longint'(VMIN) ? longint'(VMIN) : v);
    endfunction

    // (a*b)>>s truncated toward zero, magnitude capped at 2^61
    function longint mulq(longint a, longint b, int s);
      logic [63:0]  ma, mb, r;
      logic [127:0] p;
      ma = a < 0 ? 64'(-a) : 64'(a);
      mb = b < 0 ? 64'(-b) : 64'(b);
      p = ({64'd0, ma} * {64'd0, mb}) >> s;
      r = (p > {64'd0, CAP64}) ? CAP64 : p[63:0];
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // (a<<s)/d truncated toward zero, capped; zero divisor gives zero
    function longint divq(longint a, logic [63:0] d, int s);
      logic [63:0]  ma, r;
      logic [127:0] q;
      if (d == 0 || d > CAP64) return 0;
      ma = a < 0 ? 64'(-a) : 64'(a);
      q = ({64'd0, ma} << s) / {64'd0, d};
      r = (q > {64'd0, CAP64}) ? CAP64 : q[63:0];
      return a < 0 ? -longint'(r) : longint'(r);
    endfunction

    function void write_reg(logic [2:0] idx, logic [VW-1:0] data);
      case (reg_e'(idx))
        REG_KP:     kp = data[GW-1:0];
        REG_KI:     ki = data[GW-1:0];
        REG_KD:     kd = data[GW-1:0];
        REG_PERIOD: period = data[GW-1:0];
        REG_HIGH:   hi_lim = longint'(signed'(data));
        REG_LOW:    lo_lim = longint'(signed'(data));
        REG_REINIT: reinit = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic signed [VW-1:0] meas_in, logic signed [VW-1:0] sp_in,
                               logic [15:0] el);
      longint m, tf, e, pterm, kk, num, ratio, a, b, v, gap;
      bit same, hand;
      drive_t d;
      m = meas_in;
      hand = 0;
      gap = 0;
      requests++;
      if (period != 0) tf = mulq(period, STEP_K, FW);
      else if (reinit) tf = 0;
      else tf = longint'(el) * MS_K;
      // derivative on measurement
      if (!reinit || first) begin
        if (tf > 0) begin
          kk = mulq(kd, kp, FW);
          num = mulq(prev_meas - m, kk, FW);
          deriv = sat32(divq(num, tf, TFB));
          prev_meas = m;
        end
      end else begin
        prev_meas = m;
        deriv = 0;
      end
      e = sat32(longint'(sp_in) - m);
      pterm = mulq(e, kp, FW);
      if (ki != 0) begin
        same = kp == gain_hist[0] && ki == gain_hist[1] && kd == gain_hist[2];
        if (reinit || first || same) begin
          if (pterm <= hi_lim && pterm >= lo_lim) begin
            if (reinit) begin
              integ = 0;
            end else begin
              ratio = divq(kp, ki, FW);
              a = mulq(e + prev_err, ratio, FW + 1);
              b = mulq(a, tf, TFB);
              integ = sat32(b + integ);
              gap = integ;
            end
          end else begin
            integ = sat32((pterm > hi_lim ? hi_lim : lo_lim) - pterm);
            gap = integ;
          end
        end else begin
          hand = 1;
        end
      end
      if (hand) begin
        // bumpless hand-over: hold the previous drive
        integ = sat32(last_drive - (pterm + deriv));
        d.drive = last_drive[VW-1:0];
        d.limited = LIM_NONE;
        handovers++;
      end else begin
        v = pterm + gap + deriv;
        d.limited = LIM_NONE;
        if (v > hi_lim) begin
          v = hi_lim; d.limited = LIM_HIGH;
        end else if (v < lo_lim) begin
          v = lo_lim; d.limited = LIM_LOW;
        end
        if (d.limited != LIM_NONE) clamps++;
        last_drive = v;
        d.drive = v[VW-1:0];
      end
      gain_hist = '{kp, ki, kd};
      prev_err = e;
      first = 0;
      pending_drive.push_back(d);
    endfunction

    function void check_result(logic signed [VW-1:0] drive, logic [1:0] limited);
      drive_t x;
      results++;
      if (pending_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result drive=%0d limited=%0d",
                                       drive, limited);
        return;
      end
      x = pending_drive.pop_front();
      if (x.drive !== drive || x.limited !== limited) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d drive exp %0d got %0d, limited exp %0d got %0d",
                   results, x.drive, drive, x.limited, limited);
      end
    endfunction
  endclass

  logic clk, rst_n;
  pidb_in_if  req();
  pidb_out_if rsp();
  pidb_cfg_if cfg();

  pid_controller_bumpless_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  pid_scoreboard sb = new();
  longint cycles = 0;
  bit     quiet = 0;      // no idling on either side
  bit     hold_req = 0;
  int     hold_left = 0;
  int     phases = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watch handshakes and run the checks
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("pid_controller_bumpless_top regression: fail");
      $finish;
    end
    if (rst_n) begin
      if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
      if (req.valid && req.ready) sb.note_request(req.measured, req.setpoint, req.elapsed_ms);
      if (rsp.valid && rsp.ready) sb.check_result(rsp.drive, rsp.limited);
    end
  end

  // Receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
      end
    end
  end

  task automatic send(logic signed [VW-1:0] m, logic signed [VW-1:0] s, logic [15:0] el);
    if (!quiet && $urandom_range(99) < 13) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.measured   <= m;
    req.setpoint   <= s;
    req.elapsed_ms <= el;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Leaves valid high; the caller drops it after the last write
  task automatic write_reg(reg_e idx, logic [VW-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
  endtask

  task automatic set_regs(logic [GW-1:0] kp, logic [GW-1:0] ki, logic [GW-1:0] kd,
                          logic [GW-1:0] per, logic signed [VW-1:0] hi,
                          logic signed [VW-1:0] lo, bit ri);
    wait_idle();
    write_reg(REG_KP, {1'b0, kp});
    write_reg(REG_KI, {1'b0, ki});
    write_reg(REG_KD, {1'b0, kd});
    write_reg(REG_PERIOD, {1'b0, per});
    write_reg(REG_HIGH, hi);
    write_reg(REG_LOW, lo);
    write_reg(REG_REINIT, {31'd0, ri});
    cfg.valid <= 1'b0;
    phases++;
  endtask

  function automatic logic signed [VW-1:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
      default: return $signed($urandom_range(0, 33554431)) - 32'sd16777216;
    endcase
  endfunction

  function automatic logic [GW-1:0] rand_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom);
      default: return 31'($urandom_range(1, 262144));
    endcase
  endfunction

  // Measurement tracks the setpoint with noise, so the loop stays mostly in range
  task automatic random_phase(int n, bit with_hold, bit with_pause);
    logic signed [VW-1:0] sp, m;
    sp = rand_value();
    m = sp;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == 5) hold_req = 1;
      if (with_pause && i == n / 2) wait_idle();
      if ($urandom_range(9) == 0) begin
        send($urandom, $urandom, 16'($urandom));
      end else begin
        if ($urandom_range(7) == 0) sp = rand_value();
        m = m + $signed($urandom_range(0, 131071)) - 32'sd65536 + (sp - m) / 8;
        send(m, sp, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 50)));
      end
    end
  endtask

  initial begin
    req.valid = 0; req.measured = 0; req.setpoint = 0; req.elapsed_ms = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    rst_n = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: reset settings, integral disabled, field extremes
    send(32'sd0, 32'sd0, 16'd0);
    send(VMAX, VMIN, 16'hffff);
    send(VMIN, VMAX, 16'd1);
    send(32'sd65536, -32'sd65536, 16'd10);
    // Normal gains with integral, measured elapsed time, zero step time
    set_regs(31'd65536, 31'd131072, 31'd32768, 31'd0, OUT_HIGH_RST, OUT_LOW_RST, 0);
    send(32'sd0, 32'sd65536, 16'd10);
    send(32'sd32768, 32'sd65536, 16'd0);
    send(32'sd1000, 32'sd65536, 16'd20);
    send(-32'sd65536 * 200, 32'sd0, 16'd5);    // proportional beyond high limit
    send(32'sd65536 * 200, 32'sd0, 16'd5);     // proportional beyond low limit
    send(VMIN, VMAX, 16'hffff);
    // Gain hand-over on the next request
    set_regs(31'd131072, 31'd65536, 31'd65536, 31'd65536, OUT_HIGH_RST, OUT_LOW_RST, 0);
    send(32'sd100, 32'sd200, 16'd3);
    send(32'sd300, 32'sd200, 16'd3);
    // Reinit mode, fixed period and then zero step time
    set_regs(31'd65536, 31'd65536, 31'd65536, 31'd65536, OUT_HIGH_RST, OUT_LOW_RST, 1);
    send(32'sd5000, 32'sd0, 16'd7);
    send(-32'sd65536 * 300, 32'sd0, 16'd7);
    set_regs(31'd65536, 31'd65536, 31'd65536, 31'd0, OUT_HIGH_RST, OUT_LOW_RST, 1);
    send(32'sd7000, 32'sd1, 16'd9);
    // Inverted limits, full-scale limits and gains
    set_regs(31'h7fff_ffff, 31'd1, 31'h7fff_ffff, 31'h7fff_ffff, -32'sd65536, 32'sd65536, 0);
    send(32'sd0, 32'sd0, 16'd1);
    send(VMAX, VMIN, 16'hffff);
    set_regs(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'd0, VMAX, VMIN, 0);
    send(VMIN, VMAX, 16'hffff);
    send(VMAX, VMIN, 16'd1);

    // Random phases; one without idling, one with a receiver hold-off, one with a pause
    for (int p = 0; p < 10; p++) begin
      logic signed [VW-1:0] hi, lo;
      hi = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(65536, 32'h0100_0000));
      lo = $urandom_range(3) == 0 ? $urandom : -$signed($urandom_range(65536, 32'h0100_0000));
      set_regs(rand_gain(), $urandom_range(4) == 0 ? 31'd0 : rand_gain(), rand_gain(),
               $urandom_range(2) == 0 ? 31'd0 : 31'($urandom_range(1, 200000)),
               hi, lo, $urandom_range(3) == 0);
      quiet = (p == 3);
      random_phase(68, p == 5, p == 7);
    end
    quiet = 0;

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Covered %0d requests, %0d results over %0d register settings.",
             sb.requests, sb.results, phases);
    $display("Clamped results: %0d, gain hand-overs: %0d, mismatches: %0d.",
             sb.clamps, sb.handovers, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("pid_controller_bumpless_top regression: pass");
    end else begin
      $display("pid_controller_bumpless_top regression: fail");
    end
    $finish;
  end
endmodule

FILE: pid_controller_bumpless_top.f
rtl/core/pidb_pkg.sv
rtl/core/pidb_if.sv
rtl/core/pidb_front.sv
rtl/core/pidb_mul.sv
rtl/core/pidb_div.sv
rtl/core/pidb_back.sv
rtl/core/pid_controller_bumpless_top.sv
dv/tb.sv
